### rtl/core/tga_rle_pkg.sv
package tga_rle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned POS_W   = 2;
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [ADDR_W-1:0] REG_RLE_ENABLE      = 1'd1;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

    localparam int unsigned REPEAT_BIT = 7;

    typedef enum logic {
        ST_ACCEPT,
        ST_REPEAT
    } t_state;

    typedef struct packed {
        logic take;
        logic load_rep;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic rep_start;
        logic rep_end;
    } t_sts;

    function automatic logic [CNT_W-1:0] rep_count(input logic [RUN_W-1:0] run);
        rep_count = (run >= RUN_W'(2)) ? CNT_W'(2) : CNT_W'(1);
    endfunction

endpackage

### rtl/core/tga_rle_ctrl.sv
module tga_rle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  tga_rle_pkg::t_sts i_sts,
    output tga_rle_pkg::t_cmd o_cmd
);
    import tga_rle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (o_cmd.take && i_sts.rep_start) begin
                    n_state = ST_REPEAT;
                end
            end
            ST_REPEAT: begin
                if (i_sts.out_free && i_sts.rep_end) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_ACCEPT: begin
                o_s_axis_tready = i_sts.out_free;
                o_cmd.take      = i_sts.out_free && i_s_axis_tvalid;
            end
            ST_REPEAT: begin
                o_cmd.load_rep = i_sts.out_free;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // a repeat run only leaves expansion once its final beat is loaded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPEAT && !(i_sts.out_free && i_sts.rep_end))
        |=> r_state == ST_REPEAT)
        else $error("repeat expansion left early");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.take && o_cmd.load_rep))
        else $error("input beat taken during repeat expansion");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_sts.rep_start) |=> r_state == ST_REPEAT)
        else $error("long repeat run did not start expansion");

endmodule

### rtl/core/tga_rle_dp.sv
module tga_rle_dp #(
    parameter int unsigned MAX_PIXEL_BYTES = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tga_rle_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [tga_rle_pkg::BPP_W-1:0]    i_cfg_wdata,
    input  logic [tga_rle_pkg::BYTE_W-1:0]   i_byte,
    input  tga_rle_pkg::t_cmd                i_cmd,
    output tga_rle_pkg::t_sts                o_sts,
    input  logic                             i_m_axis_tready,
    output logic                             o_valid,
    output logic [tga_rle_pkg::PIXEL_W-1:0]  o_first_pixel,
    output logic [tga_rle_pkg::PIXEL_W-1:0]  o_second_pixel,
    output logic [tga_rle_pkg::CNT_W-1:0]    o_pixel_count,
    output logic                             o_run_last
);
    import tga_rle_pkg::*;

    logic [BPP_W-1:0]   r_bpp;
    logic               r_rle;
    logic [RUN_W-1:0]   r_run;
    logic               r_repeat;
    logic [POS_W-1:0]   r_pos;
    logic [PIXEL_W-1:0] r_asm;
    logic               r_valid;
    logic [PIXEL_W-1:0] r_first;
    logic [PIXEL_W-1:0] r_second;
    logic [CNT_W-1:0]   r_count;
    logic               r_last;

    logic [BPP_W-1:0]   width;
    logic               is_packet;
    logic               pix_done;
    logic               rep_pixel;
    logic [PIXEL_W-1:0] n_asm;
    logic [CNT_W-1:0]   cnt;
    logic               load_any;

    always_comb begin
        width = r_bpp;
        if (r_bpp == '0) begin
            width = BPP_W'(1);
        end else if (r_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
            width = BPP_W'(MAX_PIXEL_BYTES);
        end
    end

    always_comb begin
        n_asm = r_asm;
        case (r_pos)
            2'd0:    n_asm = {{(PIXEL_W-BYTE_W){1'b0}}, i_byte};
            2'd1:    n_asm = r_asm | {16'd0, i_byte, 8'd0};
            2'd2:    n_asm = r_asm | {8'd0, i_byte, 16'd0};
            2'd3:    n_asm = r_asm | {i_byte, 24'd0};
            default: n_asm = r_asm;
        endcase
    end

    assign is_packet = r_rle && (r_run == '0);
    assign pix_done  = !is_packet && (({1'b0, r_pos} + BPP_W'(1)) >= width);
    assign rep_pixel = pix_done && r_rle && r_repeat;
    assign cnt       = rep_count(r_run);
    assign load_any  = (i_cmd.take && pix_done) || i_cmd.load_rep;

    assign o_sts.out_free  = !r_valid || i_m_axis_tready;
    assign o_sts.rep_start = rep_pixel && (r_run > RUN_W'(2));
    assign o_sts.rep_end   = r_run <= RUN_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_RESET;
            r_rle <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BYTES_PER_PIXEL: r_bpp <= i_cfg_wdata;
                REG_RLE_ENABLE:      r_rle <= i_cfg_wdata[0];
                default:             r_bpp <= r_bpp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_repeat <= 1'b0;
            r_pos    <= '0;
            r_asm    <= '0;
        end else if (i_cmd.take) begin
            if (is_packet) begin
                r_repeat <= i_byte[REPEAT_BIT];
                r_run    <= {1'b0, i_byte[REPEAT_BIT-1:0]} + RUN_W'(1);
            end else begin
                r_asm <= n_asm;
                r_pos <= pix_done ? '0 : r_pos + POS_W'(1);
                if (pix_done) begin
                    if (rep_pixel) begin
                        r_run <= r_run - RUN_W'(cnt);
                    end else if (r_rle) begin
                        r_run <= r_run - RUN_W'(1);
                    end
                end
            end
        end else if (i_cmd.load_rep) begin
            r_run <= r_run - RUN_W'(cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_any) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rep) begin
            r_first  <= r_asm;
            r_second <= (cnt == CNT_W'(2)) ? r_asm : '0;
            r_count  <= cnt;
            r_last   <= r_run <= RUN_W'(2);
        end else if (i_cmd.take && pix_done) begin
            r_first <= n_asm;
            if (rep_pixel) begin
                r_second <= (cnt == CNT_W'(2)) ? n_asm : '0;
                r_count  <= cnt;
                r_last   <= r_run <= RUN_W'(2);
            end else begin
                r_second <= '0;
                r_count  <= CNT_W'(1);
                r_last   <= 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_first_pixel  = r_first;
    assign o_second_pixel = r_second;
    assign o_pixel_count  = r_count;
    assign o_run_last     = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= RUN_W'(128))
        else $error("run count out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < MAX_PIXEL_BYTES)
        else $error("byte position beyond pixel width");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_rep && r_run > RUN_W'(2)) |=> r_run == $past(r_run) - RUN_W'(2))
        else $error("repeat run count not stepped by two");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_any && r_valid) |-> i_m_axis_tready)
        else $error("output beat overwritten while stalled");

endmodule

### rtl/core/tga_rle_pixel_decoder.sv
// tga run-length pixel decoder
//
// slave stream: one image byte per beat on i_s_axis_tdata[7:0]
// master stream: one result per beat, tdata holds first_pixel [31:0],
//   second_pixel [63:32] (zero when one pixel), pixel_count [65:64];
//   tlast marks the last result caused by an input byte
// config: i_cfg_we with i_cfg_addr 0 = bytes_per_pixel, 1 = rle_enable
//
// the first result of a byte that completes a pixel is registered and shows
// on the master side in the cycle after the byte is accepted
// throughput: one byte per cycle for packet, literal and raw bytes while the
// output register is free; a repeat packet of n pixels emits ceil(n/2) results,
// one per cycle while the receiver takes them, and the input is held off while
// the shared output register drains the run
// reset: bytes_per_pixel 4, rle on, decoder waits for a packet byte
// stall: when the receiver holds tready low the output beat holds and the
// input side takes no new byte until that beat is taken
module tga_rle_pixel_decoder #(
    parameter int unsigned MAX_PIXEL_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // stream_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // first_pixel, second_pixel, pixel_count
    output logic        o_m_axis_tlast    // run_last
);
    import tga_rle_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [PIXEL_W-1:0] first_pixel;
    logic [PIXEL_W-1:0] second_pixel;
    logic [CNT_W-1:0]   pixel_count;

    tga_rle_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    tga_rle_dp #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_byte          (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_m_axis_tready (i_m_axis_tready),
        .o_valid         (o_m_axis_tvalid),
        .o_first_pixel   (first_pixel),
        .o_second_pixel  (second_pixel),
        .o_pixel_count   (pixel_count),
        .o_run_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, pixel_count, second_pixel, first_pixel};

endmodule
